/* rtl/sc1a_pkg.sv */
// Package for the set-1 scancode to ASCII unit.
// Holds scancode constants, the two character layers and the shared structs.
// No dependencies.
package sc1a_pkg;

  localparam int unsigned LayerLen = 58;
  localparam int unsigned LayerIdxW = $clog2(LayerLen);

  localparam logic [6:0] CodeLastLow = 7'h46;
  localparam logic [6:0] CodeF11     = 7'h57;
  localparam logic [6:0] CodeF12     = 7'h58;
  localparam logic [6:0] CodeCaps    = 7'h3A;
  localparam logic [6:0] CodeLCtrl   = 7'h1D;
  localparam logic [6:0] CodeLShift  = 7'h2A;
  localparam logic [6:0] CodeRShift  = 7'h36;
  localparam logic [6:0] CodeLAlt    = 7'h38;
  localparam logic [6:0] AsciiEsc    = 7'd27;

  localparam logic [6:0] PlainLayer [0:LayerLen-1] = '{
    7'h00, AsciiEsc, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
    7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
    7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
    7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam logic [6:0] ShiftLayer [0:LayerLen-1] = '{
    7'h00, AsciiEsc, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
    7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
    7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
    7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  typedef struct packed {
    logic lshift;
    logic rshift;
    logic ctrl;
    logic alt;
    logic caps;
  } mods_t;

  typedef struct packed {
    logic [6:0] key_code;
    logic       released;
    logic       char_valid;
    logic [6:0] ascii_char;
    logic       shift_held;
    logic       ctrl_held;
    logic       alt_held;
    logic       caps_on;
  } result_t;

endpackage

/* rtl/scancode_set1_to_ascii_unit.sv */
// AT keyboard set-1 scancode to keycode and ASCII translator, top level.
// Input register, translation logic (sc1a_xlate) and result register; uses sc1a_pkg.
//
// Takes one scancode byte per cycle while the result register is not stalled, and returns
// at most one result item per byte. An accepted byte is held in the input register,
// translated against the modifier state, and registered in the result register, which
// drives the outputs; throughput is one item per clock, limited only by the result
// register being taken. Reserved codes (including the E0/E1 prefixes) are dropped
// silently and leave the modifier state alone. Caps lock toggles on press and inverts
// the layer that shift selects, for every key.
module scancode_set1_to_ascii_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] scan_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] key_code,
  output logic       released,
  output logic       char_valid,
  output logic [6:0] ascii_char,
  output logic       shift_held,
  output logic       ctrl_held,
  output logic       alt_held,
  output logic       caps_on
);

  logic              s1_valid;
  logic [7:0]        s1_code;
  logic              s1_adv;
  sc1a_pkg::mods_t   mods;
  sc1a_pkg::mods_t   mods_next;
  logic              code_ok;
  sc1a_pkg::result_t res_next;
  sc1a_pkg::result_t res;

  sc1a_xlate u_xlate (
    .scan_code (s1_code),
    .mods      (mods),
    .code_ok   (code_ok),
    .mods_next (mods_next),
    .result    (res_next)
  );

  assign s1_adv   = ~out_valid | out_ready;
  assign in_ready = ~s1_valid | s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_code <= scan_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mods <= '0;
    end else if (s1_valid && s1_adv && code_ok) begin
      mods <= mods_next;
    end
  end

  // reserved codes advance out of the input register without a result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid & code_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid && code_ok) begin
      res <= res_next;
    end
  end

  assign key_code   = res.key_code;
  assign released   = res.released;
  assign char_valid = res.char_valid;
  assign ascii_char = res.ascii_char;
  assign shift_held = res.shift_held;
  assign ctrl_held  = res.ctrl_held;
  assign alt_held   = res.alt_held;
  assign caps_on    = res.caps_on;

endmodule

/* rtl/sc1a_xlate.sv */
// Combinational translation of one set-1 scancode byte.
// Updates the modifier state and forms the result item; uses sc1a_pkg.
module sc1a_xlate (
  input  logic [7:0]       scan_code,
  input  sc1a_pkg::mods_t  mods,
  output logic             code_ok,
  output sc1a_pkg::mods_t  mods_next,
  output sc1a_pkg::result_t result
);

  logic [6:0] make;
  logic       rel;
  logic       shift;
  logic       layer;
  logic       has_char;
  logic [sc1a_pkg::LayerIdxW-1:0] idx;
  logic [6:0] ch;

  assign make = scan_code[6:0];
  assign rel  = scan_code[7];
  assign idx  = make[sc1a_pkg::LayerIdxW-1:0];

  assign code_ok = ((make != 7'd0) && (make <= sc1a_pkg::CodeLastLow))
                   || (make == sc1a_pkg::CodeF11) || (make == sc1a_pkg::CodeF12);

  always_comb begin
    mods_next = mods;
    unique case (make)
      sc1a_pkg::CodeLShift: mods_next.lshift = ~rel;
      sc1a_pkg::CodeRShift: mods_next.rshift = ~rel;
      sc1a_pkg::CodeLCtrl:  mods_next.ctrl   = ~rel;
      sc1a_pkg::CodeLAlt:   mods_next.alt    = ~rel;
      // toggle on press only
      sc1a_pkg::CodeCaps:   mods_next.caps   = mods.caps ^ ~rel;
      default:              mods_next = mods;
    endcase
  end

  assign shift    = mods_next.lshift | mods_next.rshift;
  assign layer    = shift ^ mods_next.caps;
  assign has_char = ~rel && (make < 7'(sc1a_pkg::LayerLen));

  always_comb begin
    ch = 7'd0;
    if (has_char) begin
      ch = layer ? sc1a_pkg::ShiftLayer[idx] : sc1a_pkg::PlainLayer[idx];
    end
  end

  always_comb begin
    result.key_code   = make;
    result.released   = rel;
    result.char_valid = (ch != 7'd0);
    result.ascii_char = ch;
    result.shift_held = shift;
    result.ctrl_held  = mods_next.ctrl;
    result.alt_held   = mods_next.alt;
    result.caps_on    = mods_next.caps;
  end

endmodule
